// ===== sv/bbs_pkg.sv =====
package bbs_pkg;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int GID_W   = 9;
    localparam int TIME_W  = 32;
    localparam int LEN_W   = 24;
    localparam int LIGHT_W = 24;
    localparam int OUTC_W  = 2;
    localparam int ROWS_W  = 16;
    localparam int GCNT_W  = 9;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 1;

    localparam int NUM_GROUPS_DEF = 256;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ROW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLASH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUTC_WINDOW_OFF = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_NONE       = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_BRIGHTEST  = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_LONGEST    = 2'd3;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_WINDOW_LO = 1'd0;
    localparam logic [CIDX_W-1:0] REG_WINDOW_HI = 1'd1;

    typedef logic signed [GID_W-1:0]   gid_t;
    typedef logic        [LEN_W-1:0]   len_t;
    typedef logic signed [LIGHT_W-1:0] light_t;

endpackage

// ===== sv/bbs_if.sv =====
interface bbs_item_if import bbs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    gid_t                     group_id;
    logic signed [TIME_W-1:0] start_time;
    len_t                     track_length;
    logic                     flash_valid;
    light_t                   flash_light;

    modport source (output valid, mode, group_id, start_time, track_length,
                    flash_valid, flash_light, input ready);
    modport sink   (input valid, mode, group_id, start_time, track_length,
                    flash_valid, flash_light, output ready);
endinterface

interface bbs_result_if import bbs_pkg::*; ();
    logic              valid;
    logic              ready;
    gid_t              chosen_group;
    logic [OUTC_W-1:0] outcome;
    logic [ROWS_W-1:0] rows_in_window;
    logic [GCNT_W-1:0] groups_present;

    modport source (output valid, chosen_group, outcome, rows_in_window,
                    groups_present, input ready);
    modport sink   (input valid, chosen_group, outcome, rows_in_window,
                    groups_present, output ready);
endinterface

// ===== sv/bbs_ram.sv =====
module bbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/beam_bundle_selector.sv =====
// Channel   Dir  Fields
// item      in   mode, group_id, start_time, track_length, flash_valid, flash_light
// result    out  chosen_group, outcome, rows_in_window, groups_present
// cfg_*     in   cfg_we, cfg_index, cfg_data (window_lo = 0, window_hi = 1)
//
// Rows and flashes: the transfer cycle issues the group table read, the next
// cycle does the update (one table read-modify-write port).
// Finish: the scan walks the table once, picking the longest group and
// zeroing each entry behind it.
// After reset a clearing pass zeroes the table; item.ready stays low
// meanwhile. Config writes are taken at any time.
// The result sits in an output register; a stalled result only holds the
// block if a second finish completes before the first result is taken.
module beam_bundle_selector import bbs_pkg::*; #(
    parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bbs_item_if.sink           item,
    bbs_result_if.source       result,
    input  logic               cfg_we,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int AW = $clog2(NUM_GROUPS);
    localparam int RW = LEN_W + 1;  // {present, longest}

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_ROW      = 3'd2;
    localparam logic [2:0] ST_FLASH    = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_SCAN_END = 3'd5;
    localparam logic [2:0] ST_FIN      = 3'd6;

    // Config registers
    logic signed [CFG_W-1:0] window_lo_reg, window_hi_reg;

    // Sequencer and held item
    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     addr_reg, addr_next;
    gid_t              gid_reg, gid_next;
    len_t              len_reg, len_next;
    light_t            light_reg, light_next;
    logic              ok_reg, ok_next;

    // Event state
    light_t            bright_light_reg, bright_light_next;
    gid_t              bright_gid_reg, bright_gid_next;
    logic              tie_reg, tie_next;
    logic [ROWS_W-1:0] wcount_reg, wcount_next;
    logic [GCNT_W-1:0] gcount_reg, gcount_next;

    // Scan pipeline
    logic              eval_vld_reg, eval_vld_next;
    logic [AW-1:0]     eval_addr_reg, eval_addr_next;
    logic              best_found_reg, best_found_next;
    len_t              best_len_reg, best_len_next;
    gid_t              best_gid_reg, best_gid_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    gid_t              out_gid_reg, out_gid_next;
    logic [OUTC_W-1:0] out_outc_reg, out_outc_next;
    logic [ROWS_W-1:0] out_rows_reg, out_rows_next;
    logic [GCNT_W-1:0] out_groups_reg, out_groups_next;

    // Table port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;

    logic          accept;
    logic          gid_in_range;
    logic [31:0]   gid_ext;
    logic [31:0]   eval_ext;
    logic          in_window;
    logic          last_cnt;
    logic          rd_present;
    len_t          rd_len;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);

    assign gid_ext      = {23'b0, item.group_id};
    assign gid_in_range = !item.group_id[GID_W-1] && (gid_ext < 32'(NUM_GROUPS));
    assign in_window    = ($signed(item.start_time) >= window_lo_reg)
                          && ($signed(item.start_time) < window_hi_reg);
    assign last_cnt     = (cnt_reg == AW'(NUM_GROUPS - 1));
    assign rd_present   = ram_rdata[LEN_W];
    assign rd_len       = ram_rdata[LEN_W-1:0];
    assign eval_ext     = 32'(eval_addr_reg);

    assign result.valid          = out_valid_reg;
    assign result.chosen_group   = out_gid_reg;
    assign result.outcome        = out_outc_reg;
    assign result.rows_in_window = out_rows_reg;
    assign result.groups_present = out_groups_reg;

    bbs_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_GROUPS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Table port control
    always_comb
    begin
        ram_raddr = (state_reg == ST_SCAN) ? cnt_reg : gid_ext[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_ROW:
            begin
                ram_waddr = addr_reg;
                ram_wdata = {1'b1, len_reg};
                ram_we    = ok_reg && (!rd_present || (len_reg > rd_len));
            end
            ST_SCAN, ST_SCAN_END:
            begin
                ram_waddr = eval_addr_reg;
                ram_we    = eval_vld_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        addr_next         = addr_reg;
        gid_next          = gid_reg;
        len_next          = len_reg;
        light_next        = light_reg;
        ok_next           = ok_reg;
        bright_light_next = bright_light_reg;
        bright_gid_next   = bright_gid_reg;
        tie_next          = tie_reg;
        wcount_next       = wcount_reg;
        gcount_next       = gcount_reg;
        eval_vld_next     = 1'b0;
        eval_addr_next    = eval_addr_reg;
        best_found_next   = best_found_reg;
        best_len_next     = best_len_reg;
        best_gid_next     = best_gid_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_gid_next      = out_gid_reg;
        out_outc_next     = out_outc_reg;
        out_rows_next     = out_rows_reg;
        out_groups_next   = out_groups_reg;

        // Longest-group pick runs on each scan read return
        if (eval_vld_reg && rd_present && (!best_found_reg || (rd_len > best_len_reg)))
        begin
            best_found_next = 1'b1;
            best_len_next   = rd_len;
            best_gid_next   = eval_ext[GID_W-1:0];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = gid_ext[AW-1:0];
                    gid_next   = item.group_id;
                    len_next   = item.track_length;
                    light_next = item.flash_light;
                    case (item.mode)
                        MODE_ROW:
                        begin
                            ok_next    = gid_in_range && in_window;
                            state_next = ST_ROW;
                        end
                        MODE_FLASH:
                        begin
                            ok_next    = gid_in_range && item.flash_valid
                                         && !item.flash_light[LIGHT_W-1];
                            state_next = ST_FLASH;
                        end
                        MODE_FINISH:
                        begin
                            cnt_next        = '0;
                            best_found_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                if (ok_reg)
                begin
                    if (wcount_reg != '1)
                    begin
                        wcount_next = wcount_reg + 1'b1;
                    end
                    if (!rd_present)
                    begin
                        gcount_next = gcount_reg + 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_FLASH:
            begin
                if (ok_reg && rd_present)
                begin
                    if (light_reg > bright_light_reg)
                    begin
                        bright_light_next = light_reg;
                        bright_gid_next   = gid_reg;
                        tie_next          = 1'b0;
                    end
                    else if ((light_reg == bright_light_reg) && (gid_reg != bright_gid_reg))
                    begin
                        tie_next = 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                eval_vld_next  = 1'b1;
                eval_addr_next = cnt_reg;
                cnt_next       = cnt_reg + 1'b1;
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_gid_next    = '1;
                    out_rows_next   = wcount_reg;
                    out_groups_next = gcount_reg;
                    if (window_lo_reg >= window_hi_reg)
                    begin
                        out_outc_next   = OUTC_WINDOW_OFF;
                        out_rows_next   = '0;
                        out_groups_next = '0;
                    end
                    else if (gcount_reg == '0)
                    begin
                        out_outc_next = OUTC_NONE;
                    end
                    else if (!bright_gid_reg[GID_W-1] && !tie_reg)
                    begin
                        out_outc_next = OUTC_BRIGHTEST;
                        out_gid_next  = bright_gid_reg;
                    end
                    else
                    begin
                        out_outc_next = OUTC_LONGEST;
                        out_gid_next  = best_gid_reg;
                    end
                    // Per-event clear; the scan already zeroed the table
                    bright_light_next = '1;
                    bright_gid_next   = '1;
                    tie_next          = 1'b0;
                    wcount_next       = '0;
                    gcount_next       = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_lo_reg    <= '0;
            window_hi_reg    <= '0;
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            bright_light_reg <= '1;
            bright_gid_reg   <= '1;
            tie_reg          <= 1'b0;
            wcount_reg       <= '0;
            gcount_reg       <= '0;
            eval_vld_reg     <= 1'b0;
            best_found_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_WINDOW_LO))
            begin
                window_lo_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_WINDOW_HI))
            begin
                window_hi_reg <= cfg_data;
            end
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            bright_light_reg <= bright_light_next;
            bright_gid_reg   <= bright_gid_next;
            tie_reg          <= tie_next;
            wcount_reg       <= wcount_next;
            gcount_reg       <= gcount_next;
            eval_vld_reg     <= eval_vld_next;
            best_found_reg   <= best_found_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        gid_reg        <= gid_next;
        len_reg        <= len_next;
        light_reg      <= light_next;
        ok_reg         <= ok_next;
        eval_addr_reg  <= eval_addr_next;
        best_len_reg   <= best_len_next;
        best_gid_reg   <= best_gid_next;
        out_gid_reg    <= out_gid_next;
        out_outc_reg   <= out_outc_next;
        out_rows_reg   <= out_rows_next;
        out_groups_reg <= out_groups_next;
    end

`ifndef SYNTHESIS
    // Window off reports no counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_outc_reg == OUTC_WINDOW_OFF))
        |-> ((out_rows_reg == '0) && (out_groups_reg == '0)))
        else $error("window-off result carries counts");

    // Every new group also counted a row
    assert property (@(posedge clk) disable iff (!rst_n)
        ({{(ROWS_W-GCNT_W){1'b0}}, gcount_reg} <= wcount_reg))
        else $error("group count exceeds row count");

    // A tie needs a recorded brightest group
    assert property (@(posedge clk) disable iff (!rst_n)
        tie_reg |-> !bright_gid_reg[GID_W-1])
        else $error("tie with no brightest group");

    // Table is only written by the sequencer's busy states
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) || (state_reg == ST_FLASH) || (state_reg == ST_FIN))
        |-> !ram_we)
        else $error("table write outside update states");

    // A finished event leaves the counters cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && (state_next == ST_IDLE))
        |=> ((wcount_reg == '0) && (gcount_reg == '0) && !tie_reg))
        else $error("event state not cleared after finish");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
    import bbs_pkg::*;

    // Mode 3 has no name in the package; the block drops it without a result.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 2_000_000;
    // Covers the finish scan over all NUM_GROUPS entries; leave margin for the last update.
    localparam int SETTLE_CYCLES = NUM_GROUPS_DEF + 40;
    localparam int PHASE_ITEMS   = 142;     // minimum items queued per window setting

    typedef struct {
        logic [MODE_W-1:0]        mode;
        gid_t                     gid;
        logic signed [TIME_W-1:0] start;
        len_t                     len;
        logic                     fv;
        light_t                   light;
    } bbs_item_t;

    typedef struct {
        gid_t              grp;
        logic [OUTC_W-1:0] outc;
        logic [ROWS_W-1:0] rows;
        logic [GCNT_W-1:0] groups;
    } selection_t;

    logic clk;
    logic rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    bbs_item_if   item_ch ();
    bbs_result_if result_ch ();

    beam_bundle_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the block state, advanced on every item transfer.
    // ------------------------------------------------------------------
    logic signed [CFG_W-1:0] win_lo;
    logic signed [CFG_W-1:0] win_hi;
    len_t              group_len  [NUM_GROUPS_DEF];
    bit                group_seen [NUM_GROUPS_DEF];
    light_t            top_light;
    gid_t              top_group;
    bit                top_tied;
    logic [ROWS_W-1:0] rows_counted;
    logic [GCNT_W-1:0] groups_counted;

    bbs_item_t  items_to_send [$];
    selection_t selection_due [$];

    int  send_idle;
    int  recv_stall;
    bit  item_taken;
    int  errors;
    int  results_seen;
    int  transfers_seen;
    int  windows_used;
    int  outcome_tally [4];
    int  cycles;

    task automatic clear_event_state();
        for (int g = 0; g < NUM_GROUPS_DEF; g++)
        begin
            group_len[g]  = '0;
            group_seen[g] = 1'b0;
        end
        top_light      = -1;
        top_group      = -1;
        top_tied       = 1'b0;
        rows_counted   = '0;
        groups_counted = '0;
    endtask

    // Advance the shadow state by one item; a finish queues the selection.
    task automatic track_selection(input bbs_item_t it);
        selection_t sel;
        longint     best;
        int         idx;
        idx = int'(it.gid[7:0]);
        case (it.mode)
            MODE_ROW:
                if (it.gid >= 0 && it.start >= win_lo && it.start < win_hi)
                begin
                    if (rows_counted != '1)
                        rows_counted++;
                    if (!group_seen[idx])
                    begin
                        group_seen[idx] = 1'b1;
                        group_len[idx]  = it.len;
                        groups_counted++;
                    end
                    else if (it.len > group_len[idx])
                        group_len[idx] = it.len;
                end
            MODE_FLASH:
                if (it.fv && it.light >= 0 && it.gid >= 0 && group_seen[idx])
                begin
                    if (it.light > top_light)
                    begin
                        top_light = it.light;
                        top_group = it.gid;
                        top_tied  = 1'b0;
                    end
                    else if (it.light == top_light && it.gid != top_group)
                        top_tied = 1'b1;
                end
            MODE_FINISH:
            begin
                sel.grp    = -1;
                sel.rows   = rows_counted;
                sel.groups = groups_counted;
                if (win_lo >= win_hi)
                begin
                    sel.outc   = OUTC_WINDOW_OFF;
                    sel.rows   = '0;
                    sel.groups = '0;
                end
                else if (groups_counted == 0)
                    sel.outc = OUTC_NONE;
                else if (top_group >= 0 && !top_tied)
                begin
                    sel.outc = OUTC_BRIGHTEST;
                    sel.grp  = top_group;
                end
                else
                begin
                    // ascending scan, strictly longer wins: ties keep the lowest id
                    best = -1;
                    for (int g = 0; g < NUM_GROUPS_DEF; g++)
                        if (group_seen[g] && longint'(group_len[g]) > best)
                        begin
                            best    = longint'(group_len[g]);
                            sel.grp = 9'(g);
                        end
                    sel.outc = OUTC_LONGEST;
                end
                selection_due.push_back(sel);
                clear_event_state();
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Item builders. Fields a mode does not use carry random noise.
    // ------------------------------------------------------------------
    function automatic bbs_item_t noise_item();
        bbs_item_t   it;
        logic [31:0] r;
        r = $urandom;
        it.mode = r[1:0];
        it.gid  = r[10:2];
        it.fv   = r[11];
        r = $urandom;
        it.start = r;
        r = $urandom;
        it.len = r[23:0];
        r = $urandom;
        it.light = r[23:0];
        return it;
    endfunction

    function automatic bbs_item_t row_item(input int g, input int t, input int len);
        bbs_item_t it;
        it       = noise_item();
        it.mode  = MODE_ROW;
        it.gid   = 9'(g);
        it.start = t;
        it.len   = 24'(len);
        return it;
    endfunction

    function automatic bbs_item_t flash_item(input int g, input bit fv, input int pe);
        bbs_item_t it;
        it       = noise_item();
        it.mode  = MODE_FLASH;
        it.gid   = 9'(g);
        it.fv    = fv;
        it.light = 24'(pe);
        return it;
    endfunction

    function automatic bbs_item_t finish_item();
        bbs_item_t it;
        it      = noise_item();
        it.mode = MODE_FINISH;
        return it;
    endfunction

    function automatic int any_gid();
        logic [31:0] r;
        r = $urandom;
        return int'(gid_t'(r[8:0]));
    endfunction

    function automatic int pick_group();
        case ($urandom_range(9))
            0:       return 0;
            1:       return NUM_GROUPS_DEF - 1;
            default: return $urandom_range(0, NUM_GROUPS_DEF - 1);
        endcase
    endfunction

    // Mostly inside the current window, with its edges and outside values mixed in.
    function automatic int pick_time();
        longint      span;
        logic [31:0] r;
        r    = $urandom;
        span = longint'(win_hi) - longint'(win_lo);
        case ($urandom_range(9))
            0: return win_lo;
            1: return win_hi - 1;
            2: return win_hi;
            3: return win_lo - 1;
            4: return r;
            default:
                if (span > 0)
                    return 32'(longint'(win_lo) + (longint'(r) % span));
                else
                    return r;
        endcase
    endfunction

    // Short lengths collide often, which exercises the smallest-id rule.
    function automatic int pick_len();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(0, 7);
            5:             return 24'hFF_FFFF;
            default:       return int'(r[23:0]);
        endcase
    endfunction

    // Low light values repeat so that equal-brightness ties show up.
    function automatic int pick_light();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(0, 3);
            4:          return 24'h7F_FFFF;
            5, 6:       return int'(light_t'(r[23:0]));
            default:    return $urandom_range(0, 1000);
        endcase
    endfunction

    // One event: rows, then flashes, then a finish; some events break the order.
    task automatic queue_event(output int n);
        int pool [4];
        int pool_n;
        int g;
        n      = 0;
        pool_n = $urandom_range(1, 4);
        for (int i = 0; i < pool_n; i++)
            pool[i] = pick_group();
        repeat ($urandom_range(0, 10))
        begin
            g = ($urandom_range(9) == 0) ? any_gid() : pool[$urandom_range(0, pool_n - 1)];
            items_to_send.push_back(row_item(g, pick_time(), pick_len()));
            n++;
        end
        repeat ($urandom_range(0, 6))
        begin
            g = ($urandom_range(4) == 0) ? any_gid() : pool[$urandom_range(0, pool_n - 1)];
            items_to_send.push_back(flash_item(g, $urandom_range(99) < 85, pick_light()));
            n++;
        end
        // late rows: flashes that follow them may now count
        if ($urandom_range(99) < 15)
        begin
            g = pick_group();
            items_to_send.push_back(row_item(g, pick_time(), pick_len()));
            items_to_send.push_back(flash_item(g, 1'b1, pick_light()));
            n += 2;
        end
        if ($urandom_range(99) < 8)
        begin
            bbs_item_t junk;
            junk      = noise_item();
            junk.mode = MODE_UNUSED;
            items_to_send.push_back(junk);
        end
        items_to_send.push_back(finish_item());
        n++;
    endtask

    // Window registers are only touched while the block has nothing in flight.
    task automatic set_window(input logic signed [CFG_W-1:0] lo,
                              input logic signed [CFG_W-1:0] hi);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_LO;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= REG_WINDOW_HI;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_we    <= 1'b0;
        win_lo = lo;
        win_hi = hi;
        windows_used++;
    endtask

    // Sender holds off until every queued selection has come back, then lets
    // the block finish any row or flash update still in its pipeline.
    task automatic wait_quiet();
        while (items_to_send.size() != 0 || item_ch.valid || selection_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: item payload and result ready change at the falling edge.
    // valid stays up until the transfer seen at the last rising edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        bbs_item_t nxt;
        if (rst_n)
        begin
            if (!item_ch.valid || item_taken)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = items_to_send.pop_front();
                    item_ch.valid        <= 1'b1;
                    item_ch.mode         <= nxt.mode;
                    item_ch.group_id     <= nxt.gid;
                    item_ch.start_time   <= nxt.start;
                    item_ch.track_length <= nxt.len;
                    item_ch.flash_valid  <= nxt.fv;
                    item_ch.flash_light  <= nxt.light;
                end
                else
                    item_ch.valid <= 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results are checked against the oldest pending selection;
    // accepted items advance the shadow state.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        selection_t want;
        bbs_item_t  got;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (selection_due.size() == 0)
                begin
                    $display("%0t: unexpected result, group %0d outcome %0d", $time,
                             result_ch.chosen_group, result_ch.outcome);
                    errors++;
                end
                else
                begin
                    want = selection_due.pop_front();
                    check_field("chosen_group", want.grp, result_ch.chosen_group);
                    check_field("outcome", want.outc, result_ch.outcome);
                    check_field("rows_in_window", want.rows, result_ch.rows_in_window);
                    check_field("groups_present", want.groups, result_ch.groups_present);
                    outcome_tally[want.outc]++;
                    results_seen++;
                end
            end
            item_taken = item_ch.valid && item_ch.ready;
            if (item_taken)
            begin
                got.mode  = item_ch.mode;
                got.gid   = item_ch.group_id;
                got.start = item_ch.start_time;
                got.len   = item_ch.track_length;
                got.fv    = item_ch.flash_valid;
                got.light = item_ch.flash_light;
                track_selection(got);
                transfers_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic signed [CFG_W-1:0] lo_set [6];
        logic signed [CFG_W-1:0] hi_set [6];
        int send_set [3];
        int recv_set [3];
        int queued;
        int n;
        int w;

        // windows: wide, full range, one tick, reversed (off), positive, empty (off)
        lo_set = '{-1000, 32'sh8000_0000, 100, 32'sh7FFF_FFFF, 0, -7};
        hi_set = '{ 1000, 32'sh7FFF_FFFF, 101, 32'sh8000_0000, 65536, -7};
        send_set = '{11, 87, 0};
        recv_set = '{87, 11, 0};

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_WINDOW_LO;
        cfg_data         = '0;
        item_ch.valid        = 1'b0;
        item_ch.mode         = MODE_ROW;
        item_ch.group_id     = '0;
        item_ch.start_time   = '0;
        item_ch.track_length = '0;
        item_ch.flash_valid  = 1'b0;
        item_ch.flash_light  = '0;
        result_ch.ready  = 1'b0;
        send_idle        = 0;
        recv_stall       = 0;
        item_taken       = 1'b0;
        errors           = 0;
        results_seen     = 0;
        transfers_seen   = 0;
        windows_used     = 0;
        outcome_tally    = '{0, 0, 0, 0};
        cycles           = 0;
        win_lo           = '0;
        win_hi           = '0;
        clear_event_state();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset window is empty, so the finish reports window off
        // and hides the counts.
        items_to_send.push_back(row_item(3, 0, 5));
        items_to_send.push_back(finish_item());
        wait_quiet();

        set_window(-1000, 1000);
        // nothing present
        items_to_send.push_back(finish_item());
        // window edges, ungrouped rows, length extremes, flash filters
        items_to_send.push_back(row_item(0, -1000, 24'hFF_FFFF));
        items_to_send.push_back(row_item(255, 999, 0));
        items_to_send.push_back(row_item(7, 1000, 9));
        items_to_send.push_back(row_item(-1, 0, 9));
        items_to_send.push_back(row_item(-256, 0, 9));
        items_to_send.push_back(row_item(0, 0, 1));
        items_to_send.push_back(flash_item(255, 1'b1, 24'h7F_FFFF));
        items_to_send.push_back(flash_item(0, 1'b1, -8388608));
        items_to_send.push_back(flash_item(7, 1'b1, 24'h7F_FFFF));
        items_to_send.push_back(flash_item(0, 1'b0, 24'h7F_FFFF));
        items_to_send.push_back(flash_item(-1, 1'b1, 24'h7F_FFFF));
        begin
            bbs_item_t junk;
            junk      = noise_item();
            junk.mode = MODE_UNUSED;
            items_to_send.push_back(junk);
        end
        items_to_send.push_back(finish_item());
        // equal light from two groups: falls back to longest, equal length -> lower id
        items_to_send.push_back(row_item(10, 5, 20));
        items_to_send.push_back(row_item(4, 6, 20));
        items_to_send.push_back(flash_item(10, 1'b1, 0));
        items_to_send.push_back(flash_item(4, 1'b1, 0));
        items_to_send.push_back(finish_item());
        // a brighter flash clears the tie
        items_to_send.push_back(row_item(1, 1, 1));
        items_to_send.push_back(row_item(2, 2, 2));
        items_to_send.push_back(flash_item(1, 1'b1, 5));
        items_to_send.push_back(flash_item(2, 1'b1, 5));
        items_to_send.push_back(flash_item(1, 1'b1, 6));
        items_to_send.push_back(finish_item());
        wait_quiet();

        // Random events: three idle profiles, each over four window settings.
        for (int seg = 0; seg < 3; seg++)
        begin
            send_idle  = send_set[seg];
            recv_stall = recv_set[seg];
            for (int k = 0; k < 4; k++)
            begin
                w = (seg * 4 + k) % 6;
                set_window(lo_set[w], hi_set[w]);
                queued = 0;
                while (queued < PHASE_ITEMS)
                begin
                    queue_event(n);
                    queued += n;
                end
                wait_quiet();
            end
        end

        $display("%0d transfers, %0d selections checked across %0d window settings",
                 transfers_seen, results_seen, windows_used);
        $display("outcomes: window off %0d, none %0d, brightest %0d, longest %0d",
                 outcome_tally[OUTC_WINDOW_OFF], outcome_tally[OUTC_NONE],
                 outcome_tally[OUTC_BRIGHTEST], outcome_tally[OUTC_LONGEST]);
        if (errors == 0 && selection_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bbs_pkg.sv
sv/bbs_if.sv
sv/bbs_ram.sv
sv/beam_bundle_selector.sv
bench/tb.sv
